### rtl/ara_pkg.sv
// ----------------------------------------------------------------------------
// ara_pkg
// shared types and constants of the aligned range allocator
// ----------------------------------------------------------------------------
package ara_pkg;

  localparam int unsigned MAX_FREE_RANGES = 64;
  localparam int unsigned DATA_W          = 64;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned CFG_IDX_W       = 2;

  // request codes
  localparam logic REQ_RESERVE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_ZERO_LEN  = 3'd2,
    ST_BAD_ALIGN = 3'd3,
    ST_NO_SPACE  = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  // one free range table entry
  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] length;
  } ent_t;

endpackage

### rtl/aligned_range_allocator.sv
// ----------------------------------------------------------------------------
// aligned_range_allocator
// first-fit free range allocator with alignment and coalescing on release
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake                     | payload
// ---------+-----------+-------------------------------+---------------------------
// request  | in        | start, busy (taken: !busy)    | req_type, req_length,
//          |           |                               | req_alignment, release_address
// result   | out       | done_o, one cycle strobe      | granted_address, status
// config   | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// an error found at the request is reported in the next cycle; a reserve
//   or release scans the table entry by entry, entries are moved to open
//   or close a slot, then the entries are written back and the result reported
// the free table sits in one ram with a single read and a single write port
// after reset the S_INIT state writes the empty window into entry 0, with
//   busy high and cfg_ready_o low
// cfg_ready_o is low while busy or while start is high, so a request and a
//   register transfer never meet in one cycle
// the receiver cannot stall results; every request gives exactly one result
//
module aligned_range_allocator #(
  parameter int unsigned MAX_FREE_RANGES = ara_pkg::MAX_FREE_RANGES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type_i,
  input  logic [ara_pkg::DATA_W-1:0]     req_length_i,
  input  logic [ara_pkg::DATA_W-1:0]     req_alignment_i,
  input  logic [ara_pkg::DATA_W-1:0]     release_address_i,
  // result
  output logic                           done_o,
  output logic [ara_pkg::DATA_W-1:0]     granted_address_o,
  output logic [ara_pkg::STATUS_W-1:0]   status_o,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ara_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ara_pkg::DATA_W-1:0]     cfg_data_i
);

  import ara_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FREE_RANGES);
  localparam int unsigned CW = $clog2(MAX_FREE_RANGES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_FREE_RANGES);
  localparam logic [CW-1:0] OneCnt = CW'(1);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_RS_RD, S_RS_EV1, S_RS_EV2, S_RS_ACT,
    S_RL_RD, S_RL_EV, S_RL_DEC, S_RL_ACT,
    S_SH, S_OP_RD, S_OP_WR, S_CL_RD, S_CL_WR,
    S_WR0, S_WR1
  } state_e;

  typedef enum logic [1:0] {SH_NONE, SH_OPEN, SH_CLOSE} shift_e;

  // configuration registers
  logic              enable_q;
  logic [DATA_W-1:0] base_q, size_q;
  logic              cfg_xfer;

  // control
  state_e            state_q;
  shift_e            sh_op_q;
  logic [CW-1:0]     cnt_q, idx_q, pos_q, j_q;

  // request and scan payload
  logic [DATA_W-1:0] len_q, am1_q, addr_q, rel_end_q;
  logic [DATA_W-1:0] ent_s_q, ent_l_q, end_q, rnd_q, aend_q;
  logic [DATA_W-1:0] prev_s_q, prev_l_q, sum_q, res_q;
  logic              ovf_q, cur_valid_q, mp_q, mn_q;
  logic              w0_en_q, w1_en_q;
  logic [AW-1:0]     w0_addr_q, w1_addr_q;
  ent_t              w0_data_q, w1_data_q;

  // outputs
  logic              done_q;
  logic [DATA_W-1:0] granted_q;
  status_e           status_q;

  // ram ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  ent_t              ram_wdata, ram_rdata;

  logic [DATA_W-1:0] req_am1;
  logic              fit;
  logic              pnz, snz;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !start;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;

  assign done_o            = done_q;
  assign granted_address_o = granted_q;
  assign status_o          = status_q;

  // alignment minus one, zero alignment counts as one
  assign req_am1 = (req_alignment_i == '0) ? '0 : req_alignment_i - DATA_W'(1);

  // candidate fits when rounding did not wrap and the length stays inside
  assign fit = !ovf_q && (rnd_q <= end_q) && (len_q <= end_q - rnd_q);
  assign pnz = (rnd_q != ent_s_q);
  assign snz = (end_q != aend_q);

  // ram read address
  always_comb begin
    case (state_q)
      S_OP_RD, S_CL_RD: ram_raddr = j_q[AW-1:0];
      default:          ram_raddr = idx_q[AW-1:0];
    endcase
  end

  // ram write port: table reload, slot moves, final entry updates
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        if (cfg_xfer && cfg_index_i == CFG_BASE) begin
          ram_we    = 1'b1;
          ram_wdata = '{start: cfg_data_i, length: size_q};
        end else if (cfg_xfer && cfg_index_i == CFG_SIZE) begin
          ram_we    = 1'b1;
          ram_wdata = '{start: base_q, length: cfg_data_i};
        end
      end
      S_OP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(j_q + OneCnt);
        ram_wdata = ram_rdata;
      end
      S_CL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(j_q - OneCnt);
        ram_wdata = ram_rdata;
      end
      S_WR0: begin
        ram_we    = w0_en_q;
        ram_waddr = w0_addr_q;
        ram_wdata = w0_data_q;
      end
      S_WR1: begin
        ram_we    = w1_en_q;
        ram_waddr = w1_addr_q;
        ram_wdata = w1_data_q;
      end
      default: ;
    endcase
  end

  ara_ram #(
    .Width ($bits(ent_t)),
    .Depth (MAX_FREE_RANGES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      base_q   <= '0;
      size_q   <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index_i)
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_BASE:   base_q   <= cfg_data_i;
        CFG_SIZE:   size_q   <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // payload registers of the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        len_q     <= req_length_i;
        am1_q     <= req_am1;
        addr_q    <= release_address_i;
        rel_end_q <= release_address_i + req_length_i;
      end
      S_RS_EV1: begin
        ent_s_q <= ram_rdata.start;
        ent_l_q <= ram_rdata.length;
        end_q   <= ram_rdata.start + ram_rdata.length;
        rnd_q   <= (ram_rdata.start + am1_q) & ~am1_q;
        ovf_q   <= (am1_q != '0) && (ram_rdata.start > ~am1_q);
      end
      S_RS_EV2: begin
        aend_q <= rnd_q + len_q;
      end
      S_RS_ACT: begin
        res_q     <= rnd_q;
        w0_addr_q <= idx_q[AW-1:0];
        w1_addr_q <= AW'(idx_q + OneCnt);
        w1_data_q <= '{start: aend_q, length: end_q - aend_q};
        if (pnz) begin
          w0_data_q <= '{start: ent_s_q, length: rnd_q - ent_s_q};
        end else begin
          w0_data_q <= '{start: aend_q, length: end_q - aend_q};
        end
      end
      S_RL_EV: begin
        if (ram_rdata.start < addr_q) begin
          prev_s_q <= ram_rdata.start;
          prev_l_q <= ram_rdata.length;
        end else begin
          ent_s_q <= ram_rdata.start;
          ent_l_q <= ram_rdata.length;
        end
      end
      S_RL_DEC: begin
        mp_q  <= (idx_q != '0) && (prev_s_q + prev_l_q == addr_q);
        mn_q  <= cur_valid_q && (rel_end_q == ent_s_q);
        sum_q <= prev_l_q + len_q;
      end
      S_RL_ACT: begin
        res_q <= '0;
        if (mp_q) begin
          w0_addr_q <= AW'(idx_q - OneCnt);
          w0_data_q <= '{start: prev_s_q, length: mn_q ? sum_q + ent_l_q : sum_q};
        end else if (mn_q) begin
          w0_addr_q <= idx_q[AW-1:0];
          w0_data_q <= '{start: addr_q, length: ent_l_q + len_q};
        end else begin
          w0_addr_q <= idx_q[AW-1:0];
          w0_data_q <= '{start: addr_q, length: len_q};
        end
      end
      default: ;
    endcase
  end

  // sequencer: scan, decide, move entries, write back, report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sh_op_q     <= SH_NONE;
      cnt_q       <= OneCnt;
      idx_q       <= '0;
      pos_q       <= '0;
      j_q         <= '0;
      cur_valid_q <= 1'b0;
      w0_en_q     <= 1'b0;
      w1_en_q     <= 1'b0;
      done_q      <= 1'b0;
      granted_q   <= '0;
      status_q    <= ST_OK;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          state_q <= S_IDLE;
        end
        S_IDLE: begin
          idx_q       <= '0;
          cur_valid_q <= 1'b0;
          if (cfg_xfer && (cfg_index_i == CFG_BASE || cfg_index_i == CFG_SIZE)) begin
            cnt_q <= OneCnt;
          end else if (start) begin
            if (!enable_q) begin
              done_q    <= 1'b1;
              granted_q <= '0;
              status_q  <= ST_DISABLED;
            end else if (req_length_i == '0) begin
              done_q    <= 1'b1;
              granted_q <= '0;
              status_q  <= ST_ZERO_LEN;
            end else if (req_type_i == REQ_RESERVE &&
                         (req_alignment_i & (req_alignment_i - DATA_W'(1))) != '0) begin
              done_q    <= 1'b1;
              granted_q <= '0;
              status_q  <= ST_BAD_ALIGN;
            end else if (req_type_i == REQ_RESERVE) begin
              state_q <= S_RS_RD;
            end else begin
              state_q <= S_RL_RD;
            end
          end
        end
        // reserve: first-fit scan
        S_RS_RD: begin
          if (idx_q >= cnt_q) begin
            done_q    <= 1'b1;
            granted_q <= '0;
            status_q  <= ST_NO_SPACE;
            state_q   <= S_IDLE;
          end else begin
            state_q <= S_RS_EV1;
          end
        end
        S_RS_EV1: state_q <= S_RS_EV2;
        S_RS_EV2: begin
          if (fit) begin
            state_q <= S_RS_ACT;
          end else begin
            idx_q   <= idx_q + OneCnt;
            state_q <= S_RS_RD;
          end
        end
        S_RS_ACT: begin
          w1_en_q <= 1'b0;
          if (pnz && snz) begin
            if (cnt_q >= MaxCnt) begin
              // split would need a slot the table does not have
              done_q    <= 1'b1;
              granted_q <= '0;
              status_q  <= ST_FULL;
              state_q   <= S_IDLE;
            end else begin
              sh_op_q <= SH_OPEN;
              pos_q   <= idx_q + OneCnt;
              w0_en_q <= 1'b1;
              w1_en_q <= 1'b1;
              state_q <= S_SH;
            end
          end else if (pnz || snz) begin
            sh_op_q <= SH_NONE;
            w0_en_q <= 1'b1;
            state_q <= S_SH;
          end else begin
            // exact fit, drop the entry
            sh_op_q <= SH_CLOSE;
            pos_q   <= idx_q;
            w0_en_q <= 1'b0;
            state_q <= S_SH;
          end
        end
        // release: find first entry not below the address
        S_RL_RD: begin
          if (idx_q >= cnt_q) begin
            state_q <= S_RL_DEC;
          end else begin
            state_q <= S_RL_EV;
          end
        end
        S_RL_EV: begin
          if (ram_rdata.start < addr_q) begin
            idx_q   <= idx_q + OneCnt;
            state_q <= S_RL_RD;
          end else begin
            cur_valid_q <= 1'b1;
            state_q     <= S_RL_DEC;
          end
        end
        S_RL_DEC: state_q <= S_RL_ACT;
        S_RL_ACT: begin
          w0_en_q <= 1'b1;
          w1_en_q <= 1'b0;
          if (mp_q && mn_q) begin
            // bridges two neighbors, the upper one goes away
            sh_op_q <= SH_CLOSE;
            pos_q   <= idx_q;
            state_q <= S_SH;
          end else if (mp_q || mn_q) begin
            sh_op_q <= SH_NONE;
            state_q <= S_SH;
          end else if (cnt_q >= MaxCnt) begin
            // no neighbor and no room, range is dropped
            done_q    <= 1'b1;
            granted_q <= '0;
            status_q  <= ST_FULL;
            state_q   <= S_IDLE;
          end else begin
            sh_op_q <= SH_OPEN;
            pos_q   <= idx_q;
            state_q <= S_SH;
          end
        end
        // slot moves
        S_SH: begin
          case (sh_op_q)
            SH_OPEN: begin
              if (cnt_q > pos_q) begin
                j_q     <= cnt_q - OneCnt;
                state_q <= S_OP_RD;
              end else begin
                cnt_q   <= cnt_q + OneCnt;
                state_q <= S_WR0;
              end
            end
            SH_CLOSE: begin
              if (pos_q + OneCnt < cnt_q) begin
                j_q     <= pos_q + OneCnt;
                state_q <= S_CL_RD;
              end else begin
                cnt_q   <= cnt_q - OneCnt;
                state_q <= S_WR0;
              end
            end
            default: state_q <= S_WR0;
          endcase
        end
        S_OP_RD: state_q <= S_OP_WR;
        S_OP_WR: begin
          if (j_q == pos_q) begin
            cnt_q   <= cnt_q + OneCnt;
            state_q <= S_WR0;
          end else begin
            j_q     <= j_q - OneCnt;
            state_q <= S_OP_RD;
          end
        end
        S_CL_RD: state_q <= S_CL_WR;
        S_CL_WR: begin
          if (j_q + OneCnt == cnt_q) begin
            cnt_q   <= cnt_q - OneCnt;
            state_q <= S_WR0;
          end else begin
            j_q     <= j_q + OneCnt;
            state_q <= S_CL_RD;
          end
        end
        S_WR0: state_q <= S_WR1;
        S_WR1: begin
          done_q    <= 1'b1;
          granted_q <= res_q;
          status_q  <= ST_OK;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // table never holds more ranges than it has slots
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("free range count above table size");

  // an accepted request is either in flight or reported in the next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !cfg_valid_i |=> busy || done_o)
    else $error("request accepted without progress");

  // errors never carry an address
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> granted_address_o == '0)
    else $error("error result with nonzero address");

  // a result marks the end of the request, the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");

endmodule

### rtl/ara_ram.sv
// ----------------------------------------------------------------------------
// ara_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ara_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/tb_aligned_range_allocator.sv
// ----------------------------------------------------------------------------
// tb_aligned_range_allocator
// self-checking testbench of the aligned range allocator
// ----------------------------------------------------------------------------
// Keeps its own copy of the free range table and predicts the address and
// status of every request. It runs a short directed sequence, then random
// phases under several window settings: reserves and releases of
// ranges that were really granted, plus scattered releases that fragment
// the table until it fills. Request gaps come in random bursts. Results are
// checked field by field in order.
// ----------------------------------------------------------------------------
module tb_aligned_range_allocator;
  import ara_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  typedef struct {
    logic              kind;
    logic [DATA_W-1:0] length;
    logic [DATA_W-1:0] align;
    logic [DATA_W-1:0] addr;
  } request_t;

  typedef struct {
    logic              kind;
    logic [DATA_W-1:0] length;
    logic [DATA_W-1:0] granted;
    status_e           status;
  } outcome_t;

  typedef struct {
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] length;
  } grant_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 req_type_i = REQ_RESERVE;
  logic [DATA_W-1:0]    req_length_i = '0;
  logic [DATA_W-1:0]    req_alignment_i = '0;
  logic [DATA_W-1:0]    release_address_i = '0;
  logic                 done_o;
  logic [DATA_W-1:0]    granted_address_o;
  logic [STATUS_W-1:0]  status_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_ENABLE;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  aligned_range_allocator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .req_length_i     (req_length_i),
    .req_alignment_i  (req_alignment_i),
    .release_address_i(release_address_i),
    .done_o           (done_o),
    .granted_address_o(granted_address_o),
    .status_o         (status_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predicted free range table
  // ---------------------------------------------------------------------------
  logic              model_en;
  logic [DATA_W-1:0] model_base;
  logic [DATA_W-1:0] model_size;
  logic [DATA_W-1:0] range_lo  [MAX_FREE_RANGES];
  logic [DATA_W-1:0] range_len [MAX_FREE_RANGES];
  int unsigned       range_cnt;

  function automatic void reload_table();
    for (int i = 0; i < MAX_FREE_RANGES; i++) begin
      range_lo[i]  = '0;
      range_len[i] = '0;
    end
    range_lo[0]  = model_base;
    range_len[0] = model_size;
    range_cnt    = 1;
  endfunction

  // shift entries up from pos to make room
  function automatic void make_hole(int unsigned pos);
    for (int unsigned k = range_cnt; k > pos; k--) begin
      range_lo[k]  = range_lo[k-1];
      range_len[k] = range_len[k-1];
    end
    range_cnt++;
  endfunction

  function automatic void drop_entry(int unsigned pos);
    for (int unsigned k = pos; k + 1 < range_cnt; k++) begin
      range_lo[k]  = range_lo[k+1];
      range_len[k] = range_len[k+1];
    end
    range_cnt--;
    range_lo[range_cnt]  = '0;
    range_len[range_cnt] = '0;
  endfunction

  function automatic status_e reserve_range(logic [DATA_W-1:0] len, logic [DATA_W-1:0] align,
                                            output logic [DATA_W-1:0] granted);
    logic [DATA_W-1:0] a, top, pre, post;
    int unsigned       hit;
    logic              fits;
    granted = '0;
    a       = '0;
    if (!model_en) return ST_DISABLED;
    if (len == '0) return ST_ZERO_LEN;
    if ((align & (align - 1)) != '0) return ST_BAD_ALIGN;
    if (align == '0) align = 1;
    hit = range_cnt;
    for (int unsigned i = 0; i < range_cnt; i++) begin
      top  = range_lo[i] + range_len[i];
      fits = 1'b1;
      a    = range_lo[i];
      // ranges too close to the top of the address space to round up are skipped
      if (align > 1) begin
        if (range_lo[i] > ALL_ONES - (align - 1)) fits = 1'b0;
        else a = (range_lo[i] + (align - 1)) & ~(align - 1);
      end
      if (fits && a <= top && len <= top - a) begin
        hit = i;
        break;
      end
    end
    if (hit >= range_cnt) return ST_NO_SPACE;
    top  = range_lo[hit] + range_len[hit];
    pre  = a - range_lo[hit];
    post = top - (a + len);
    if (pre != '0 && post != '0) begin
      if (range_cnt >= MAX_FREE_RANGES) return ST_FULL;
      make_hole(hit + 1);
      range_len[hit]  = pre;
      range_lo[hit+1] = a + len;
      range_len[hit+1] = post;
    end else if (pre != '0) begin
      range_len[hit] = pre;
    end else if (post != '0) begin
      range_lo[hit]  = a + len;
      range_len[hit] = post;
    end else begin
      drop_entry(hit);
    end
    granted = a;
    return ST_OK;
  endfunction

  function automatic status_e release_range(logic [DATA_W-1:0] addr, logic [DATA_W-1:0] len);
    int unsigned n;
    logic        joined_lo;
    n         = 0;
    joined_lo = 1'b0;
    if (!model_en) return ST_DISABLED;
    if (len == '0) return ST_ZERO_LEN;
    while (n < range_cnt && range_lo[n] < addr) n++;
    if (n > 0 && range_lo[n-1] + range_len[n-1] == addr) begin
      range_len[n-1] += len;
      joined_lo = 1'b1;
    end
    if (n < range_cnt && addr + len == range_lo[n]) begin
      if (joined_lo) begin
        range_len[n-1] += range_len[n];
        drop_entry(n);
      end else begin
        range_lo[n]  = addr;
        range_len[n] += len;
      end
      return ST_OK;
    end
    if (joined_lo) return ST_OK;
    // no neighbor and no free slot: the range is lost
    if (range_cnt >= MAX_FREE_RANGES) return ST_FULL;
    make_hole(n);
    range_lo[n]  = addr;
    range_len[n] = len;
    return ST_OK;
  endfunction

  // ---------------------------------------------------------------------------
  // queues and flags
  // ---------------------------------------------------------------------------
  request_t pending_reqs[$];
  outcome_t awaited[$];
  grant_t   live_grants[$];
  bit       failed = 1'b0;
  bit       calm = 1'b0;      // no request gaps in the last part of the run
  int       gap_left = 0;

  // ---------------------------------------------------------------------------
  // driver: one request transfer per start && !busy edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    request_t r;
    outcome_t o;
    logic     go;
    go = start;
    if (rst_ni && start && !busy) begin
      r = pending_reqs.pop_front();
      o.kind   = r.kind;
      o.length = r.length;
      if (r.kind == REQ_RESERVE) o.status = reserve_range(r.length, r.align, o.granted);
      else begin
        o.granted = '0;
        o.status  = release_range(r.addr, r.length);
      end
      awaited.push_back(o);
      go = 1'b0;
      if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 11);
    end
    if (rst_ni && !go) begin
      if (gap_left > 0) gap_left--;
      else if (pending_reqs.size() > 0) begin
        r = pending_reqs[0];
        go                = 1'b1;
        req_type_i        <= r.kind;
        req_length_i      <= r.length;
        req_alignment_i   <= r.align;
        release_address_i <= r.addr;
      end
    end
    start <= go;
  end

  // ---------------------------------------------------------------------------
  // monitor: results are single-cycle strobes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    outcome_t o;
    grant_t   g;
    if (rst_ni && done_o) begin
      if (awaited.size() == 0) begin
        $display("%0t: result with none awaited: addr %h status %0d", $time,
                 granted_address_o, status_o);
        failed = 1'b1;
      end else begin
        o = awaited.pop_front();
        if (granted_address_o !== o.granted) begin
          $display("%0t: granted_address expected %h actual %h", $time, o.granted,
                   granted_address_o);
          failed = 1'b1;
        end
        if (status_o !== o.status) begin
          $display("%0t: status expected %0d actual %0d", $time, o.status, status_o);
          failed = 1'b1;
        end
        // remember real grants so later releases are well formed
        if (o.kind == REQ_RESERVE && o.status == ST_OK) begin
          g.addr   = o.granted;
          g.length = o.length;
          live_grants.push_back(g);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send(logic kind, logic [DATA_W-1:0] len, logic [DATA_W-1:0] align,
                      logic [DATA_W-1:0] addr);
    request_t r;
    r.kind   = kind;
    r.length = len;
    r.align  = align;
    r.addr   = addr;
    while (pending_reqs.size() > 2) @(posedge clk_i);
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || awaited.size() > 0 || start || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register transfer on cfg_valid_i && cfg_ready_o
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ENABLE: model_en = val[0];
      CFG_BASE: begin
        model_base = val;
        reload_table();
      end
      CFG_SIZE: begin
        model_size = val;
        reload_table();
      end
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] wide_rand();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DATA_W-1:0] pick_len(bit wide);
    if (wide && $urandom_range(0, 3) == 0) return wide_rand();
    if ($urandom_range(0, 31) == 0) return '0;
    return DATA_W'($urandom_range(1, 1 << $urandom_range(0, 12)));
  endfunction

  function automatic logic [DATA_W-1:0] pick_align();
    int unsigned c;
    c = $urandom_range(0, 15);
    if (c == 0) return '0;
    if (c == 1) return wide_rand() | 64'h3;   // never a power of two
    if (c < 4) return DATA_W'(1) << $urandom_range(0, 63);
    return DATA_W'(1) << $urandom_range(0, 9);
  endfunction

  // one random request; mostly reserves and releases of real grants
  task automatic random_req(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] span, bit wide,
                            int unsigned scatter_pct);
    grant_t      g;
    int unsigned c, k;
    c = $urandom_range(0, 99);
    if (c < scatter_pct) begin
      // scattered release, fragments the table
      if (wide && $urandom_range(0, 3) == 0) send(REQ_RELEASE, pick_len(1), '0, wide_rand());
      else send(REQ_RELEASE, DATA_W'($urandom_range(1, 8)), '0,
                lo + (wide_rand() % (span + 1)));
    end else if (c < scatter_pct + 35 && live_grants.size() > 0) begin
      k = $urandom_range(0, live_grants.size() - 1);
      g = live_grants[k];
      live_grants.delete(k);
      send(REQ_RELEASE, g.length, '0, g.addr);
    end else begin
      send(REQ_RESERVE, pick_len(wide), pick_align(), wide_rand());
    end
  endtask

  task automatic random_phase(logic [DATA_W-1:0] base, logic [DATA_W-1:0] size, int unsigned n,
                              bit wide, int unsigned scatter_pct);
    drain();
    live_grants.delete();
    write_reg(CFG_BASE, base);
    write_reg(CFG_SIZE, size);
    repeat (n) random_req(base, (size > 64'h1_0000) ? 64'h1_0000 : size + 64'h100, wide,
                          scatter_pct);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    model_en   = 1'b0;
    model_base = '0;
    model_size = '0;
    reload_table();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // block disabled after reset
    send(REQ_RESERVE, 64'h10, '0, '0);
    send(REQ_RELEASE, 64'h10, '0, 64'h40);
    drain();

    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_BASE, 64'h1000);
    write_reg(CFG_SIZE, 64'h1000);
    send(REQ_RESERVE, '0, '0, '0);                       // zero length
    send(REQ_RELEASE, '0, '0, 64'h2000);                 // zero length release
    send(REQ_RESERVE, 64'h10, 64'h3, '0);                // bad alignment
    send(REQ_RESERVE, 64'h10, '0, '0);                   // alignment zero, trims front
    send(REQ_RESERVE, 64'h10, 64'h100, '0);              // splits the range
    send(REQ_RESERVE, ALL_ONES, '0, '0);                 // no space
    send(REQ_RESERVE, 64'h1, 64'h8000_0000_0000_0000, '0);
    send(REQ_RELEASE, 64'h10, '0, 64'h1000);             // merges with the next range
    send(REQ_RELEASE, 64'h10, '0, 64'h1100);             // merges on both sides
    send(REQ_RESERVE, 64'h1000, 64'h1, '0);              // takes the whole range
    send(REQ_RESERVE, 64'h1, '0, '0);                    // empty table
    send(REQ_RELEASE, 64'h1000, '0, 64'h1000);           // into an empty table
    drain();

    // window at the top of the address space, its end wraps
    write_reg(CFG_BASE, ALL_ONES - 64'hff);
    write_reg(CFG_SIZE, 64'h200);
    send(REQ_RESERVE, 64'h10, 64'h100, '0);              // no space, the end wraps below the start
    send(REQ_RESERVE, 64'h10, '0, '0);
    drain();
    write_reg(CFG_SIZE, '0);                             // empty window
    send(REQ_RESERVE, 64'h1, '0, '0);
    drain();

    random_phase(64'h0, 64'h1_0000, 450, 1'b0, 8);
    random_phase(wide_rand(), DATA_W'($urandom_range(1, 1 << 16)), 250, 1'b1, 10);
    random_phase(64'h0, 64'h100, 350, 1'b0, 45);        // fills the table
    drain();
    write_reg(CFG_ENABLE, 0);
    repeat (20) random_req(64'h0, 64'h100, 1'b1, 20);
    drain();
    write_reg(CFG_ENABLE, 1);
    random_phase(64'h0, ALL_ONES, 300, 1'b1, 15);
    random_phase(ALL_ONES - 64'hfff, 64'h2000, 150, 1'b1, 10);
    drain();
    calm = 1'b1;
    random_phase(64'h1000, 64'h8000, 200, 1'b0, 10);

    drain();
    repeat (400) @(posedge clk_i);
    if (!failed) begin
      $display("** aligned_range_allocator: PASSED **");
    end else begin
      $display("** aligned_range_allocator: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("** aligned_range_allocator: FAILED **");
    $finish;
  end

endmodule

### aligned_range_allocator.f
rtl/ara_pkg.sv
rtl/ara_ram.sv
rtl/aligned_range_allocator.sv
tb/tb_aligned_range_allocator.sv
